/* sv/fcv_pkg.sv */
// Shared types, constants and tables of the flow color visualizer.
package fcv_pkg;

   localparam int WHEEL_ENTRIES = 55;
   localparam int CORDIC_STEPS = 20;
   localparam int DIV_STEPS = 32;
   localparam int ROOT_STEPS = 16;
   localparam int CH_COUNT = 3;
   localparam logic [31:0] LEN2_RESET = 32'd4096;

   // Arctangent of 2^-i in turns, 2^32 for a full turn.
   localparam logic [31:0] TURN_TABLE [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
   };

   // Hue wheel, red in [23:16], green in [15:8], blue in [7:0].
   localparam logic [23:0] HUE_WHEEL [WHEEL_ENTRIES] = '{
      24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400,
      24'hFF5500, 24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900,
      24'hFFAA00, 24'hFFBB00, 24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
      24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00, 24'h2BFF00,
      24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
      24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF, 24'h008CFF,
      24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF, 24'h0018FF,
      24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF, 24'h6200FF,
      24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF, 24'hC400FF, 24'hD700FF,
      24'hEB00FF,
      24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055, 24'hFF002B
   };

   typedef struct packed {
      logic       load;
      logic       square;
      logic       sum;
      logic       prep;
      logic       run;
      logic       root;
      logic       mix;
      logic       paint;
      logic       emit;
      logic [4:0] iter;
      logic [1:0] chan;
   } fcv_cmd_type;

   typedef struct packed {
      logic mode;
      logic flow_valid;
      logic out_busy;
   } fcv_stat_type;

endpackage

/* sv/fcv_ctrl.sv */
// Sequencer that steps one flow item through the datapath.
module fcv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  fcv_pkg::fcv_stat_type stat,
   output fcv_pkg::fcv_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQUARE = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_PREP   = 4'd3;
   localparam logic [3:0] ST_RUN    = 4'd4;
   localparam logic [3:0] ST_ROOT   = 4'd5;
   localparam logic [3:0] ST_MIX    = 4'd6;
   localparam logic [3:0] ST_PAINT  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] iter_ff, iter_in;
   logic [1:0] chan_ff, chan_in;

   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      chan_in    = chan_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.iter   = iter_ff;
      cmd.chan   = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (!stat.mode) begin
               state_in = ST_IDLE;
            end else if (!stat.flow_valid) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            iter_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(fcv_pkg::DIV_STEPS - 1)) begin
               iter_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            iter_in  = iter_ff + 5'd1;
            if (iter_ff == 5'(fcv_pkg::ROOT_STEPS - 1)) begin
               iter_in  = '0;
               chan_in  = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_PAINT;
         end
         ST_PAINT: begin
            cmd.paint = 1'b1;
            if (chan_ff == 2'(fcv_pkg::CH_COUNT - 1)) begin
               state_in = ST_DONE;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_MIX;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

/* sv/fcv_dp.sv */
// Datapath: squares, maximum length, CORDIC angle, divider, square root and color mix.
module fcv_dp #(
   parameter int FLOW_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fcv_pkg::fcv_cmd_type        cmd,
   output fcv_pkg::fcv_stat_type       stat,
   input  logic                        mode,
   input  logic                        restart,
   input  logic signed [FLOW_BITS-1:0] flow_x,
   input  logic signed [FLOW_BITS-1:0] flow_y,
   input  logic                        flow_valid,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [7:0]                  red,
   output logic [7:0]                  green,
   output logic [7:0]                  blue,
   output logic                        painted
);

   localparam int SQ_W = 2 * FLOW_BITS;
   localparam int SUM_W = (SQ_W + 1 > 33) ? SQ_W + 1 : 33;
   localparam int CW = FLOW_BITS + 27;

   logic                        mode_ff, valid_ff;
   logic signed [FLOW_BITS-1:0] fx_ff, fy_ff;
   logic signed [SQ_W-1:0]      px, py;
   logic [SQ_W-1:0]             sqx_ff, sqy_ff;
   logic [SUM_W-1:0]            sum;
   logic [31:0]                 l2, l2_ff, max_ff;
   logic                        inside_ff, equal_ff, zero_ff;
   logic signed [CW-1:0]        cx_ff, cy_ff, x0, y0, xs, ys;
   logic [31:0]                 acc_ff, turn;
   logic [31:0]                 rem_ff, quo_ff;
   logic [32:0]                 rem2, rem_sub;
   logic [15:0]                 root_ff, root_try;
   logic [31:0]                 root_sq;
   logic [31:0]                 acc_round;
   logic [15:0]                 phase;
   logic [21:0]                 fk;
   logic [5:0]                  k0_ff, k1;
   logic [15:0]                 f_ff;
   logic [23:0]                 w0, w1;
   logic [7:0]                  c0, c1;
   logic [16:0]                 wt0;
   logic [24:0]                 blend;
   logic [23:0]                 mix_ff;
   logic [16:0]                 rad;
   logic [23:0]                 gap;
   logic [40:0]                 shade;
   logic [39:0]                 lit;
   logic [25:0]                 dim;
   logic [7:0]                  level;
   logic [7:0]                  red_ff, green_ff, blue_ff;
   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                        rsp_painted_ff;

   assign px  = fx_ff * fx_ff;
   assign py  = fy_ff * fy_ff;
   assign sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
   assign l2  = (|sum[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];

   // scale the vector for the CORDIC loop; prep folds the left half plane onto the right one
   assign x0 = CW'(fx_ff) <<< 24;
   assign y0 = CW'(fy_ff) <<< 24;

   // shifts truncate toward zero
   assign xs   = cx_ff[CW-1] ? -((-cx_ff) >>> cmd.iter) : (cx_ff >>> cmd.iter);
   assign ys   = cy_ff[CW-1] ? -((-cy_ff) >>> cmd.iter) : (cy_ff >>> cmd.iter);
   assign turn = (cmd.iter < 5'(fcv_pkg::CORDIC_STEPS)) ? fcv_pkg::TURN_TABLE[cmd.iter] : '0;

   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, max_ff};

   assign root_try = root_ff | (16'h8000 >> cmd.iter[3:0]);
   assign root_sq  = 32'(root_try) * 32'(root_try);

   assign acc_round = acc_ff + 32'h0000_8000;
   assign phase     = zero_ff ? 16'd0 : acc_round[31:16];
   assign fk        = 22'(phase) * 22'(fcv_pkg::WHEEL_ENTRIES - 1);

   assign k1 = (k0_ff == 6'(fcv_pkg::WHEEL_ENTRIES - 1)) ? 6'd0 : k0_ff + 6'd1;
   assign w0 = fcv_pkg::HUE_WHEEL[k0_ff];
   assign w1 = fcv_pkg::HUE_WHEEL[k1];

   always_comb begin
      case (cmd.chan)
         2'd0: begin
            c0 = w0[23:16];
            c1 = w1[23:16];
         end
         2'd1: begin
            c0 = w0[15:8];
            c1 = w1[15:8];
         end
         default: begin
            c0 = w0[7:0];
            c1 = w1[7:0];
         end
      endcase
   end

   assign wt0   = 17'h1_0000 - 17'(f_ff);
   assign blend = 25'(wt0) * 25'(c0) + 25'(f_ff) * 25'(c1);

   assign rad   = equal_ff ? 17'h1_0000 : 17'(root_ff);
   assign gap   = 24'hFF_0000 - mix_ff;
   assign shade = 41'(rad) * 41'(gap);
   assign lit   = 40'hFF_0000_0000 - shade[39:0];
   assign dim   = 26'(mix_ff) + {1'b0, mix_ff, 1'b0};
   assign level = inside_ff ? lit[39:32] : dim[25:18];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode;
         valid_ff <= flow_valid;
         fx_ff    <= flow_x;
         fy_ff    <= flow_y;
      end
      if (cmd.square) begin
         sqx_ff <= px;
         sqy_ff <= py;
      end
      if (cmd.sum) begin
         l2_ff <= l2;
      end
      if (cmd.prep) begin
         inside_ff <= l2_ff <= max_ff;
         equal_ff  <= l2_ff == max_ff;
         zero_ff   <= (fx_ff == '0) && (fy_ff == '0);
         rem_ff    <= l2_ff;
         quo_ff    <= '0;
         root_ff   <= '0;
         if (x0[CW-1]) begin
            cx_ff  <= -x0;
            cy_ff  <= -y0;
            acc_ff <= 32'h8000_0000;
         end else begin
            cx_ff  <= x0;
            cy_ff  <= y0;
            acc_ff <= '0;
         end
      end
      if (cmd.run) begin
         if (cmd.iter < 5'(fcv_pkg::CORDIC_STEPS)) begin
            if (!cy_ff[CW-1]) begin
               cx_ff  <= cx_ff + ys;
               cy_ff  <= cy_ff - xs;
               acc_ff <= acc_ff + turn;
            end else begin
               cx_ff  <= cx_ff - ys;
               cy_ff  <= cy_ff + xs;
               acc_ff <= acc_ff - turn;
            end
         end
         // restoring division, one quotient bit per cycle
         if (!rem_sub[32]) begin
            rem_ff <= rem_sub[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem2[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.root) begin
         if (root_sq <= quo_ff) begin
            root_ff <= root_try;
         end
         k0_ff <= fk[21:16];
         f_ff  <= fk[15:0];
      end
      if (cmd.mix) begin
         mix_ff <= blend[23:0];
      end
      if (cmd.paint) begin
         case (cmd.chan)
            2'd0:    red_ff   <= level;
            2'd1:    green_ff <= level;
            default: blue_ff  <= level;
         endcase
      end
      if (cmd.emit) begin
         rsp_red_ff     <= valid_ff ? red_ff : 8'd0;
         rsp_green_ff   <= valid_ff ? green_ff : 8'd0;
         rsp_blue_ff    <= valid_ff ? blue_ff : 8'd0;
         rsp_painted_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= fcv_pkg::LEN2_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && restart) begin
            max_ff <= fcv_pkg::LEN2_RESET;
         end else if (cmd.sum && !mode_ff && valid_ff && (l2 > max_ff)) begin
            max_ff <= l2;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.mode       = mode_ff;
   assign stat.flow_valid = valid_ff;
   assign stat.out_busy   = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign red        = rsp_red_ff;
   assign green      = rsp_green_ff;
   assign blue       = rsp_blue_ff;
   assign painted    = rsp_painted_ff;

endmodule

/* sv/flow_color_visualizer.sv */
// Optical flow color coder. Items are taken one at a time. A measure item (mode 0) goes
// through square, sum and update of the maximum squared length before the next item can
// be taken. A color item with a valid vector steps through square, sum and set up, the
// radix-2 divider (len2 * 2^32 / max), which the 20-step CORDIC angle loop shares, the
// bit-by-bit square root, mix and shade of the three channels and the load of the output
// register. An invalid color item skips the divider, root and mix and gives black. The
// output register lets a new item be taken while a result still waits; a finished result
// waits there until it is taken.
module flow_color_visualizer #(
   parameter int FLOW_BITS = 16,
   localparam int REQ_DATA_W = ((2 * FLOW_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // flow_x, flow_y, zero padding
   input  logic [2:0]            req_tuser,  // mode, restart, flow_valid
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // red, green, blue
   output logic [0:0]            rsp_tuser   // painted
);

   fcv_pkg::fcv_cmd_type  cmd;
   fcv_pkg::fcv_stat_type stat;
   logic [7:0]            red, green, blue;
   logic                  painted;

   fcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fcv_dp #(
      .FLOW_BITS (FLOW_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .mode       (req_tuser[0]),
      .restart    (req_tuser[1]),
      .flow_x     (req_tdata[FLOW_BITS-1:0]),
      .flow_y     (req_tdata[2*FLOW_BITS-1:FLOW_BITS]),
      .flow_valid (req_tuser[2]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .red        (red),
      .green      (green),
      .blue       (blue),
      .painted    (painted)
   );

   assign rsp_tdata = {blue, green, red};
   assign rsp_tuser = painted;

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("unpainted result is not black");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");
`endif

endmodule
